FILE: design/periodic_task_dispatcher_macros.svh
`ifndef PERIODIC_TASK_DISPATCHER_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ptd_pkg.sv
package ptd_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int TICK_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int SLOT_W     = 4;
    localparam int MASK_W     = 8;
    localparam int REQ_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_CREATE = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

FILE: design/periodic_task_dispatcher.sv
// Periodic task dispatcher.
// Input channel (in_valid/in_ready) carries one request item: req_type, slot, period.
// Output channel (out_valid/out_ready) returns one result item per request:
// status, fire_mask and tick_value.
// Create, delete and unused codes complete in the accept cycle; the result is
// written into the output register on acceptance.
// A tick increments the counter and scans the slots one at a time: the period
// of each valid slot is read from the period memory and the counter is divided
// by it in a bit-serial remainder unit. A valid slot whose period is zero is
// skipped and never fires.
// One item is in work at a time. A new item is taken only while the block is
// idle and the output register is empty or being emptied, so a result that
// waits for the receiver holds off the next item.
// A stalled receiver holds the result and payload steady; a finished tick then
// waits until the output register frees.
// Reset clears the counter, all valid marks and the output valid flag; the
// period memory is not cleared and its read data is used only for valid slots.
module periodic_task_dispatcher #(
    parameter int NUM_TASKS = ptd_pkg::MAX_TASKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptd_pkg::REQ_W-1:0]     req_type,
    input  logic [ptd_pkg::SLOT_W-1:0]    slot,
    input  logic [ptd_pkg::PERIOD_W-1:0]  period,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [ptd_pkg::MASK_W-1:0]    fire_mask,
    output logic [ptd_pkg::TICK_W-1:0]    tick_value
);

`include "periodic_task_dispatcher_macros.svh"

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(ptd_pkg::TICK_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ptd_pkg::TICK_W - 1);

    logic [ptd_pkg::PERIOD_W-1:0] period_mem [NUM_TASKS];
    logic [ptd_pkg::PERIOD_W-1:0] rd_data_reg;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;

    ptd_pkg::state_t              state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [ptd_pkg::PERIOD_W-1:0] rem_reg, rem_next;
    logic [ptd_pkg::TICK_W-1:0]   dvd_reg, dvd_next;
    logic [ptd_pkg::PERIOD_W-1:0] div_reg, div_next;
    logic [NUM_TASKS-1:0]         mask_reg, mask_next;
    logic [ptd_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [NUM_TASKS-1:0]         valid_reg, valid_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_status_reg, out_status_next;
    logic [ptd_pkg::MASK_W-1:0]   out_mask_reg, out_mask_next;
    logic [ptd_pkg::TICK_W-1:0]   out_tick_reg, out_tick_next;

    logic                         accept;
    logic                         out_free;
    logic                         slot_ok;
    logic [IDX_W-1:0]             slot_idx;
    logic [ptd_pkg::PERIOD_W:0]   trial;
    logic [ptd_pkg::PERIOD_W-1:0] rem_step;
    ptd_pkg::req_t                req;

    assign req       = ptd_pkg::req_t'(req_type);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ptd_pkg::S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign slot_ok   = 32'(slot) < NUM_TASKS;
    assign slot_idx  = slot[IDX_W-1:0];

    assign trial     = {rem_reg, dvd_reg[ptd_pkg::TICK_W-1]} - {1'b0, div_reg};
    assign rem_step  = trial[ptd_pkg::PERIOD_W] ?
                       {rem_reg[ptd_pkg::PERIOD_W-2:0], dvd_reg[ptd_pkg::TICK_W-1]} :
                       trial[ptd_pkg::PERIOD_W-1:0];

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign fire_mask  = out_mask_reg;
    assign tick_value = out_tick_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            period_mem[mem_waddr] <= period;
        end
        rd_data_reg <= period_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptd_pkg::S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            tick_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            tick_reg      <= tick_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        div_reg        <= div_next;
        out_status_reg <= out_status_next;
        out_mask_reg   <= out_mask_next;
        out_tick_reg   <= out_tick_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        div_next        = div_reg;
        mask_next       = mask_reg;
        tick_next       = tick_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_mask_next   = out_mask_reg;
        out_tick_next   = out_tick_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_idx;

        unique case (state_reg)
            ptd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        ptd_pkg::REQ_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            idx_next   = '0;
                            mask_next  = '0;
                            state_next = ptd_pkg::S_SCAN;
                        end
                        ptd_pkg::REQ_CREATE:
                        begin
                            out_valid_next = 1'b1;
                            out_mask_next  = '0;
                            out_tick_next  = tick_reg;
                            if (slot_ok && !valid_reg[slot_idx])
                            begin
                                mem_we               = 1'b1;
                                valid_next[slot_idx] = 1'b1;
                                out_status_next      = ptd_pkg::STATUS_OK;
                            end
                            else
                            begin
                                out_status_next = ptd_pkg::STATUS_FAIL;
                            end
                        end
                        ptd_pkg::REQ_DELETE:
                        begin
                            if (slot_ok)
                            begin
                                valid_next[slot_idx] = 1'b0;
                            end
                            out_valid_next  = 1'b1;
                            out_status_next = ptd_pkg::STATUS_OK;
                            out_mask_next   = '0;
                            out_tick_next   = tick_reg;
                        end
                        ptd_pkg::REQ_NONE:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ptd_pkg::STATUS_OK;
                            out_mask_next   = '0;
                            out_tick_next   = tick_reg;
                        end
                    endcase
                end
            end
            ptd_pkg::S_SCAN:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = ptd_pkg::S_LOAD;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ptd_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ptd_pkg::S_LOAD:
            begin
                if (rd_data_reg == '0)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ptd_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ptd_pkg::S_SCAN;
                    end
                end
                else
                begin
                    div_next   = rd_data_reg;
                    dvd_next   = tick_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ptd_pkg::S_DIV;
                end
            end
            ptd_pkg::S_DIV:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[ptd_pkg::TICK_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    if (rem_step == '0)
                    begin
                        mask_next[idx_reg] = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ptd_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ptd_pkg::S_SCAN;
                    end
                end
            end
            ptd_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ptd_pkg::STATUS_OK;
                    out_mask_next   = ptd_pkg::MASK_W'(mask_reg);
                    out_tick_next   = tick_reg;
                    state_next      = ptd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptd_pkg::S_IDLE;
            end
        endcase
    end

    `PTD_ASSERT_NEXT(a_tick_advance,
        accept && (req_type == ptd_pkg::REQ_TICK),
        tick_reg == $past(tick_reg) + 1'b1,
        "tick counter did not advance on tick")

    `PTD_ASSERT_NEXT(a_table_result_now,
        accept && (req_type != ptd_pkg::REQ_TICK),
        out_valid_reg && (out_mask_reg == '0) && (out_tick_reg == tick_reg),
        "table request result missing or wrong")

    `PTD_ASSERT_NOW(a_div_nonzero,
        state_reg == ptd_pkg::S_DIV,
        (div_reg != '0) && valid_reg[idx_reg],
        "remainder unit running on a free slot or zero period")

    `PTD_ASSERT_NEXT(a_tick_no_early_result,
        accept && (req_type == ptd_pkg::REQ_TICK),
        !out_valid_reg,
        "tick result presented before the scan")

endmodule
